### rtl/iolm_pkg.sv
// Shared types, constants, decode and microcode tables for the indexed order list mover.
package iolm_pkg;

    // Sizing
    localparam int MAX_ITEMS  = 1024;
    localparam int NODE_COUNT = MAX_ITEMS + 2;
    localparam int ID_W       = $clog2(NODE_COUNT);
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;

    typedef logic [ID_W-1:0]     id_t;
    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam id_t MAX_ID = id_t'(MAX_ITEMS);

    // Operation codes
    localparam op_t OP_FRONT   = 3'd0;
    localparam op_t OP_BACK    = 3'd1;
    localparam op_t OP_AFTER   = 3'd2;
    localparam op_t OP_QUERY   = 3'd3;
    localparam op_t OP_REBUILD = 3'd4;

    // Status codes
    localparam status_t STS_DONE   = 2'd0;
    localparam status_t STS_BAD_ID = 2'd1;
    localparam status_t STS_SAME   = 2'd2;

    // What an accepted item turns into
    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_FRONT,
        CLS_BACK,
        CLS_AFTER,
        CLS_QUERY,
        CLS_REBUILD
    } op_class_t;

    typedef struct packed {
        op_class_t cls;
        status_t   status;
    } decode_t;

    // Microprogram addresses
    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_UNLINK,
        STEP_FIND_TAIL,
        STEP_LINK_X,
        STEP_LINK_Y,
        STEP_QUERY,
        STEP_REPLY,
        STEP_SWEEP
    } step_t;

    // Read address sources
    typedef enum logic [2:0] {
        RD_IN,
        RD_ITEM,
        RD_Y,
        RD_BWDQ,
        RD_TAIL
    } rd_sel_t;

    // Forward table write sources
    typedef enum logic [2:0] {
        WF_NONE,
        WF_UNLINK,
        WF_LINK_X,
        WF_LINK_Y,
        WF_SWEEP
    } wf_sel_t;

    // Backward table write sources
    typedef enum logic [2:0] {
        WB_NONE,
        WB_UNLINK,
        WB_LINK_X,
        WB_LINK_N,
        WB_SWEEP
    } wb_sel_t;

    // Jump conditions
    typedef enum logic [2:0] {
        JC_GOTO,
        JC_DISPATCH,
        JC_BACK_OR,
        JC_SWEEP,
        JC_EMIT
    } jump_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_STATUS,
        RES_QUERY
    } res_sel_t;

    typedef struct packed {
        rd_sel_t  rf;
        rd_sel_t  rb;
        wf_sel_t  wf;
        wb_sel_t  wb;
        logic     ld_y;
        logic     ld_n2;
        logic     cnt_inc;
        res_sel_t res;
        jump_t    jc;
        step_t    target;
    } ctrl_word_t;

    typedef struct packed {
        logic      accept;
        logic      sweep_req;
        op_class_t cls;
        logic      is_back;
        logic      at_tail;
        logic      emit_done;
    } seq_flags_t;

    // Classify an item and check its ids against the current count
    function automatic decode_t decode_op(input op_t op, input id_t item, input id_t anchor,
                                          input id_t count);
        decode_t d;
        d.cls    = CLS_NONE;
        d.status = STS_DONE;
        case (op) inside
            OP_FRONT, OP_BACK, OP_AFTER: begin
                if (item == '0 || item > count) begin
                    d.status = STS_BAD_ID;
                end else if (op == OP_AFTER && anchor > count) begin
                    d.status = STS_BAD_ID;
                end else if (op == OP_AFTER && anchor == item) begin
                    d.status = STS_SAME;
                end else if (op == OP_FRONT) begin
                    d.cls = CLS_FRONT;
                end else if (op == OP_BACK) begin
                    d.cls = CLS_BACK;
                end else begin
                    d.cls = CLS_AFTER;
                end
            end
            OP_QUERY: begin
                if (item > count) begin
                    d.status = STS_BAD_ID;
                end else begin
                    d.cls = CLS_QUERY;
                end
            end
            OP_REBUILD: d.cls = CLS_REBUILD;
            default: d.cls = CLS_NONE;
        endcase
        return d;
    endfunction

    // Dispatch table: entry step for each class
    function automatic step_t dispatch(input op_class_t cls);
        step_t s;
        unique case (cls)
            CLS_FRONT, CLS_BACK, CLS_AFTER: s = STEP_UNLINK;
            CLS_QUERY:                      s = STEP_QUERY;
            CLS_REBUILD:                    s = STEP_SWEEP;
            default:                        s = STEP_REPLY;
        endcase
        return s;
    endfunction

    // Control store: one word per step
    function automatic ctrl_word_t microcode(input step_t step);
        ctrl_word_t w;
        w = '0;
        unique case (step)
            STEP_IDLE: begin
                w.rf = RD_IN;   w.rb = RD_IN;
                w.jc = JC_DISPATCH;
                w.target = STEP_IDLE;
            end
            STEP_UNLINK: begin
                // splice the item out; fetch anchor successor and tail predecessor
                w.rf = RD_Y;    w.rb = RD_TAIL;
                w.wf = WF_UNLINK; w.wb = WB_UNLINK;
                w.jc = JC_BACK_OR;
                w.target = STEP_LINK_X;
            end
            STEP_FIND_TAIL: begin
                w.rf = RD_BWDQ; w.rb = RD_TAIL;
                w.ld_y = 1'b1;
                w.jc = JC_GOTO;
                w.target = STEP_LINK_X;
            end
            STEP_LINK_X: begin
                w.rf = RD_Y;    w.rb = RD_ITEM;
                w.wf = WF_LINK_X; w.wb = WB_LINK_X;
                w.ld_n2 = 1'b1;
                w.jc = JC_GOTO;
                w.target = STEP_LINK_Y;
            end
            STEP_LINK_Y: begin
                w.rf = RD_ITEM; w.rb = RD_ITEM;
                w.wf = WF_LINK_Y; w.wb = WB_LINK_N;
                w.res = RES_STATUS;
                w.jc = JC_EMIT;
                w.target = STEP_IDLE;
            end
            STEP_QUERY: begin
                w.rf = RD_ITEM; w.rb = RD_ITEM;
                w.res = RES_QUERY;
                w.jc = JC_EMIT;
                w.target = STEP_IDLE;
            end
            STEP_REPLY: begin
                w.rf = RD_ITEM; w.rb = RD_ITEM;
                w.res = RES_STATUS;
                w.jc = JC_EMIT;
                w.target = STEP_IDLE;
            end
            STEP_SWEEP: begin
                w.rf = RD_ITEM; w.rb = RD_ITEM;
                w.wf = WF_SWEEP; w.wb = WB_SWEEP;
                w.cnt_inc = 1'b1;
                w.jc = JC_SWEEP;
                w.target = STEP_REPLY;
            end
            default: begin
                w.jc = JC_GOTO;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/iolm_link_ram.sv
// One link table: single write port, one registered read port with write-first bypass.
module iolm_link_ram (
    input  logic            aclk,
    input  logic            wr_en,
    input  iolm_pkg::id_t   wr_addr,
    input  iolm_pkg::id_t   wr_data,
    input  iolm_pkg::id_t   rd_addr,
    output iolm_pkg::id_t   rd_data
);
    import iolm_pkg::*;

    id_t mem [NODE_COUNT];
    id_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port; a same-cycle write to the read address is returned
    always_ff @(posedge aclk) begin
        if (wr_en && wr_addr == rd_addr) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/iolm_sequencer.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
module iolm_sequencer (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  iolm_pkg::seq_flags_t    flags,
    output iolm_pkg::ctrl_word_t    ctrl,
    output iolm_pkg::step_t         step
);
    import iolm_pkg::*;

    step_t step_reg;
    step_t step_next;

    // control word for the current step
    always_comb begin
        ctrl = microcode(step_reg);
    end

    // next step
    always_comb begin
        step_next = step_reg;
        unique case (ctrl.jc)
            JC_GOTO: step_next = ctrl.target;
            JC_DISPATCH: begin
                if (flags.sweep_req) begin
                    step_next = STEP_SWEEP;
                end else if (flags.accept) begin
                    step_next = dispatch(flags.cls);
                end else begin
                    step_next = ctrl.target;
                end
            end
            JC_BACK_OR: begin
                if (flags.is_back) begin
                    step_next = step_t'(step_reg + 3'd1);
                end else begin
                    step_next = ctrl.target;
                end
            end
            JC_SWEEP: begin
                if (flags.at_tail) begin
                    step_next = ctrl.target;
                end
            end
            JC_EMIT: begin
                if (flags.emit_done) begin
                    step_next = ctrl.target;
                end
            end
            default: step_next = STEP_IDLE;
        endcase
    end

    // reset starts with a rebuild sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_SWEEP;
        end else begin
            step_reg <= step_next;
        end
    end

    assign step = step_reg;

endmodule

### rtl/indexed_order_list_mover.sv
// Top level: operand datapath, link tables, sequencer and result register.
//
// Channels: items enter on s_* (operation, item, anchor) with s_valid/s_ready,
// results leave on m_* (status, next_item) with m_valid/m_ready, one result
// per item. The item count is written on cfg_* and is taken only while idle;
// each write saturates the count to 1..1024 and rebuilds the chain 1..count.
// Steps after acceptance, up to the next acceptance:
//   move to front or after anchor: unlink, link item, link anchor
//   move to back: unlink, dependent read of the tail's predecessor, link item, link anchor
//   successor query: query step; rejected items: reply step
//   rebuild: a sweep of one link table entry pair per cycle, then a reply step
// Each step makes at most one dependent read and one write per link table.
// The result sits in an output register; the next item is taken while it
// waits, but that item's result holds its last step until the register is
// free, so a stalled receiver stalls the block.
// Reset: the count returns to 1024 and a sweep rebuilds both tables;
// s_ready and cfg_ready stay low until it ends.
module indexed_order_list_mover (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  iolm_pkg::id_t             cfg_item_count,
    // items in
    input  logic                      s_valid,
    output logic                      s_ready,
    input  iolm_pkg::op_t             s_operation,
    input  iolm_pkg::id_t             s_item,
    input  iolm_pkg::id_t             s_anchor,
    // results out
    output logic                      m_valid,
    input  logic                      m_ready,
    output iolm_pkg::status_t         m_status,
    output iolm_pkg::id_t             m_next_item
);
    import iolm_pkg::*;

    ctrl_word_t ctrl;
    step_t      step;
    seq_flags_t flags;
    decode_t    dec;

    // control state
    id_t     count_reg,     count_next;
    logic    sweep_req_reg, sweep_req_next;
    logic    res_pend_reg,  res_pend_next;
    logic    m_valid_reg,   m_valid_next;
    id_t     cnt_reg,       cnt_next;

    // payload
    id_t     item_reg;
    id_t     y_reg;
    id_t     n2_reg;
    status_t status_reg;
    logic    back_reg;
    status_t m_status_reg;
    id_t     m_next_item_reg;

    // link table ports
    logic fwd_we, bwd_we;
    id_t  fwd_waddr, fwd_wdata, fwd_raddr, fwd_q;
    id_t  bwd_waddr, bwd_wdata, bwd_raddr, bwd_q;

    id_t     tail;
    logic    s_accept, cfg_accept, out_load;
    id_t     cfg_sat;
    status_t res_status;
    id_t     res_next;

    assign tail = count_reg + 1'b1;

    // handshakes; configuration wins over an item in the same cycle
    assign cfg_ready  = (step == STEP_IDLE) && !sweep_req_reg;
    assign s_ready    = (step == STEP_IDLE) && !sweep_req_reg && !cfg_valid;
    assign s_accept   = s_valid && s_ready;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign dec = decode_op(s_operation, s_item, s_anchor, count_reg);

    // count saturation
    always_comb begin
        if (cfg_item_count == '0) begin
            cfg_sat = id_t'(1);
        end else if (cfg_item_count > MAX_ID) begin
            cfg_sat = MAX_ID;
        end else begin
            cfg_sat = cfg_item_count;
        end
    end

    // read address selection
    always_comb begin
        case (ctrl.rf)
            RD_IN:   fwd_raddr = s_item;
            RD_Y:    fwd_raddr = y_reg;
            RD_BWDQ: fwd_raddr = bwd_q;
            RD_TAIL: fwd_raddr = tail;
            default: fwd_raddr = item_reg;
        endcase
        case (ctrl.rb)
            RD_IN:   bwd_raddr = s_item;
            RD_Y:    bwd_raddr = y_reg;
            RD_BWDQ: bwd_raddr = bwd_q;
            RD_TAIL: bwd_raddr = tail;
            default: bwd_raddr = item_reg;
        endcase
    end

    // forward table writes
    always_comb begin
        fwd_we    = 1'b1;
        fwd_waddr = item_reg;
        fwd_wdata = fwd_q;
        case (ctrl.wf)
            WF_UNLINK: begin
                fwd_waddr = bwd_q;
                fwd_wdata = fwd_q;
            end
            WF_LINK_X: begin
                fwd_waddr = item_reg;
                fwd_wdata = fwd_q;
            end
            WF_LINK_Y: begin
                fwd_waddr = y_reg;
                fwd_wdata = item_reg;
            end
            WF_SWEEP: begin
                fwd_waddr = cnt_reg;
                fwd_wdata = cnt_reg + 1'b1;
            end
            default: fwd_we = 1'b0;
        endcase
    end

    // backward table writes
    always_comb begin
        bwd_we    = 1'b1;
        bwd_waddr = item_reg;
        bwd_wdata = bwd_q;
        case (ctrl.wb)
            WB_UNLINK: begin
                bwd_waddr = fwd_q;
                bwd_wdata = bwd_q;
            end
            WB_LINK_X: begin
                bwd_waddr = item_reg;
                bwd_wdata = y_reg;
            end
            WB_LINK_N: begin
                bwd_waddr = n2_reg;
                bwd_wdata = item_reg;
            end
            WB_SWEEP: begin
                bwd_waddr = cnt_reg;
                bwd_wdata = cnt_reg - 1'b1;
            end
            default: bwd_we = 1'b0;
        endcase
    end

    // result formatting; the tail reads back as end of list
    always_comb begin
        res_status = status_reg;
        res_next   = '0;
        if (ctrl.res == RES_QUERY && fwd_q != tail) begin
            res_next = fwd_q;
        end
    end

    assign out_load = (ctrl.res != RES_NONE) && res_pend_reg && (!m_valid_reg || m_ready);

    // sequencer flags
    always_comb begin
        flags.accept    = s_accept;
        flags.sweep_req = sweep_req_reg;
        flags.cls       = dec.cls;
        flags.is_back   = back_reg;
        flags.at_tail   = (cnt_reg == tail);
        flags.emit_done = out_load || !res_pend_reg;
    end

    // control state next values
    always_comb begin
        count_next     = cfg_accept ? cfg_sat : count_reg;
        sweep_req_next = sweep_req_reg;
        if (cfg_accept) begin
            sweep_req_next = 1'b1;
        end else if (step == STEP_IDLE) begin
            sweep_req_next = 1'b0;
        end
        res_pend_next = res_pend_reg;
        if (s_accept) begin
            res_pend_next = 1'b1;
        end else if (out_load) begin
            res_pend_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        cnt_next = ctrl.cnt_inc ? cnt_reg + 1'b1 : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= MAX_ID;
            sweep_req_reg <= 1'b0;
            res_pend_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            count_reg     <= count_next;
            sweep_req_reg <= sweep_req_next;
            res_pend_reg  <= res_pend_next;
            m_valid_reg   <= m_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // operand and result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg   <= s_item;
            y_reg      <= (dec.cls == CLS_AFTER) ? s_anchor : '0;
            status_reg <= dec.status;
            back_reg   <= (dec.cls == CLS_BACK);
        end else if (ctrl.ld_y) begin
            y_reg <= bwd_q;
        end
        if (ctrl.ld_n2) begin
            n2_reg <= fwd_q;
        end
        if (out_load) begin
            m_status_reg    <= res_status;
            m_next_item_reg <= res_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_next_item = m_next_item_reg;

    iolm_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl),
        .step    (step)
    );

    iolm_link_ram u_fwd (
        .aclk    (aclk),
        .wr_en   (fwd_we),
        .wr_addr (fwd_waddr),
        .wr_data (fwd_wdata),
        .rd_addr (fwd_raddr),
        .rd_data (fwd_q)
    );

    iolm_link_ram u_bwd (
        .aclk    (aclk),
        .wr_en   (bwd_we),
        .wr_addr (bwd_waddr),
        .wr_data (bwd_wdata),
        .rd_addr (bwd_raddr),
        .rd_data (bwd_q)
    );

endmodule

### rtl/iolm_checker.sv
// Port-level checks for the order list mover, bound to the top level.
module iolm_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input iolm_pkg::status_t    m_status,
    input iolm_pkg::id_t        m_next_item
);
    import iolm_pkg::*;

    // reset drops any result and starts the rebuild sweep
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("result or input ready right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_next_item))
        else $error("stalled result changed");

    // only a successful query carries a successor
    a_next_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STS_DONE |-> m_next_item == '0)
        else $error("successor given with a failure status");

    // a pending count write keeps items out
    a_cfg_first: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> !s_ready)
        else $error("item taken alongside a count write");

    // a count write is followed by the rebuild sweep
    a_cfg_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_ready && !cfg_ready)
        else $error("ready during rebuild after a count write");

endmodule

bind indexed_order_list_mover iolm_checker u_checker (.*);

### test/indexed_order_list_mover_test.sv
// Self-checking testbench for the indexed order list mover: link-table predictor and scoreboard.
`timescale 1ns / 1ps

module indexed_order_list_mover_test;

    import iolm_pkg::*;

    // Spare operation codes: accepted, answered with done, no effect
    localparam op_t OP_SPARE_LO  = 3'd5;
    localparam op_t OP_SPARE_MID = 3'd6;
    localparam op_t OP_SPARE_HI  = 3'd7;

    localparam id_t ID_ALL_ONES  = '1;
    localparam int  QUIET_LIMIT  = 20000;  // well above the reset sweep and a full rebuild
    localparam int  END_SLACK    = 40;
    localparam int  PHASE_ITEMS  = 95;
    localparam int  NUM_PHASES   = 10;

    typedef struct packed {
        status_t status;
        id_t     next_item;
    } reply_t;

    // Scoreboard: keeps its own copy of both link tables and the item count
    class order_chain_checker;
        id_t    fwd_link [NODE_COUNT];
        id_t    bwd_link [NODE_COUNT];
        id_t    count;
        reply_t pending_replies [$];
        int     mismatches;

        function new();
            mismatches = 0;
            count      = MAX_ID;
            relink();
        endfunction

        // Chain head, 1..count, tail; everything else cleared
        function void relink();
            int i;
            for (i = 0; i < NODE_COUNT; i++) begin
                fwd_link[i] = '0;
                bwd_link[i] = '0;
            end
            for (i = 0; i <= int'(count); i++) begin
                fwd_link[i]     = id_t'(i + 1);
                bwd_link[i + 1] = id_t'(i);
            end
        endfunction

        // Count write saturates to 1..MAX_ITEMS and rebuilds the chain
        function void load_count(id_t v);
            if (v == '0)
                v = id_t'(1);
            if (v > MAX_ID)
                v = MAX_ID;
            count = v;
            relink();
        endfunction

        function void unlink(id_t x);
            id_t p;
            id_t n;
            p = bwd_link[x];
            n = fwd_link[x];
            fwd_link[p] = n;
            bwd_link[n] = p;
        endfunction

        function void link_after(id_t y, id_t x);
            id_t n;
            n = fwd_link[y];
            fwd_link[x] = n;
            bwd_link[x] = y;
            bwd_link[n] = x;
            fwd_link[y] = x;
        endfunction

        // Apply one accepted item and queue the reply it should produce
        function void note_item(op_t op, id_t item, id_t anchor);
            reply_t r;
            id_t    tail;
            r.status    = STS_DONE;
            r.next_item = '0;
            tail        = count + id_t'(1);
            case (op) inside
                OP_FRONT, OP_BACK, OP_AFTER: begin
                    if (item == '0 || item > count) begin
                        r.status = STS_BAD_ID;
                    end else if (op == OP_AFTER && anchor > count) begin
                        r.status = STS_BAD_ID;
                    end else if (op == OP_AFTER && anchor == item) begin
                        r.status = STS_SAME;
                    end else begin
                        unlink(item);
                        if (op == OP_FRONT)
                            link_after('0, item);
                        else if (op == OP_BACK)
                            link_after(bwd_link[tail], item);
                        else
                            link_after(anchor, item);
                    end
                end
                OP_QUERY: begin
                    if (item > count) begin
                        r.status = STS_BAD_ID;
                    end else begin
                        r.next_item = fwd_link[item];
                        if (r.next_item == tail)
                            r.next_item = '0;
                    end
                end
                OP_REBUILD: relink();
                default: ;
            endcase
            pending_replies.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare one accepted result with the oldest outstanding reply
        task check_reply(status_t status, id_t next_item);
            reply_t r;
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("result (status %0d, next %0d) with no item outstanding",
                                          status, next_item));
            end else begin
                r = pending_replies.pop_front();
                if (status !== r.status)
                    report_mismatch($sformatf("status %0d, want %0d", status, r.status));
                if (next_item !== r.next_item)
                    report_mismatch($sformatf("next_item %0d, want %0d", next_item,
                                              r.next_item));
            end
        endtask
    endclass

    logic    aclk;
    logic    aresetn;
    logic    cfg_valid;
    logic    cfg_ready;
    id_t     cfg_item_count;
    logic    s_valid;
    logic    s_ready;
    op_t     s_operation;
    id_t     s_item;
    id_t     s_anchor;
    logic    m_valid;
    logic    m_ready;
    status_t m_status;
    id_t     m_next_item;

    order_chain_checker sb;
    int snd_idle_pct;
    int rcv_idle_pct;
    int quiet_cycles;

    indexed_order_list_mover u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_item_count (cfg_item_count),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_item         (s_item),
        .s_anchor       (s_anchor),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_next_item    (m_next_item)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Handshake monitor: every accepted item, count write and result
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.load_count(cfg_item_count);
            if (s_valid && s_ready)
                sb.note_item(s_operation, s_item, s_anchor);
            if (m_valid && m_ready)
                sb.check_reply(m_status, m_next_item);
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver back-pressure, rerolled every cycle
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Present one item; entered and left on a falling edge
    task automatic send_item(op_t op, id_t item, id_t anchor);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_item      <= item;
        s_anchor    <= anchor;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_count(id_t v);
        cfg_valid      <= 1'b1;
        cfg_item_count <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait until every reply is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending_replies.size() != 0)
            @(negedge aclk);
    endtask

    // Random item, mostly in range for the current count
    task automatic make_item(id_t c, output op_t op, output id_t it, output id_t an);
        int pick;
        pick = $urandom_range(0, 99);
        an   = id_t'($urandom);
        if (pick < 22)      op = OP_FRONT;
        else if (pick < 42) op = OP_BACK;
        else if (pick < 66) op = OP_AFTER;
        else if (pick < 94) op = OP_QUERY;
        else if (pick < 96) op = OP_REBUILD;
        else                op = op_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        if ($urandom_range(0, 99) < 12)
            it = id_t'($urandom);
        else if (op == OP_QUERY)
            it = id_t'($urandom_range(0, c));
        else
            it = id_t'($urandom_range(1, c));
        if (op == OP_AFTER) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                an = it;
            else if (pick >= 20)
                an = id_t'($urandom_range(0, c));
        end
    endtask

    initial begin : main
        id_t counts [NUM_PHASES];
        op_t op;
        id_t it;
        id_t an;
        int  ph;
        int  k;

        counts = '{11'd0, 11'd2, 11'd2047, 11'd5, 11'd12, 11'd1, 11'd3, 11'd1024,
                   11'd40, 11'd7};
        sb             = new();
        snd_idle_pct   = 26;
        rcv_idle_pct   = 46;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_item_count = '0;
        s_valid        = 1'b0;
        s_operation    = OP_FRONT;
        s_item         = '0;
        s_anchor       = '0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: full-size chain straight out of reset
        send_item(OP_QUERY, '0, '0);
        send_item(OP_QUERY, MAX_ID, '0);                 // last item: end of list
        send_item(OP_QUERY, MAX_ID + id_t'(1), '0);      // tail node is not a valid id
        send_item(OP_QUERY, ID_ALL_ONES, ID_ALL_ONES);
        send_item(OP_FRONT, MAX_ID, '0);
        send_item(OP_FRONT, MAX_ID, '0);                 // already in front
        send_item(OP_BACK, id_t'(1), '0);
        send_item(OP_BACK, id_t'(1), '0);                // already at the back
        send_item(OP_AFTER, id_t'(5), '0);               // head anchor
        send_item(OP_AFTER, id_t'(7), MAX_ID);
        send_item(OP_AFTER, id_t'(3), id_t'(3));         // moved after itself
        send_item(OP_AFTER, '0, '0);                     // bad item wins over same id
        send_item(OP_AFTER, ID_ALL_ONES, ID_ALL_ONES);
        send_item(OP_AFTER, id_t'(9), MAX_ID + id_t'(1));
        send_item(OP_AFTER, id_t'(9), ID_ALL_ONES);
        send_item(OP_FRONT, '0, ID_ALL_ONES);
        send_item(OP_BACK, MAX_ID + id_t'(1), '0);
        send_item(OP_SPARE_LO, ID_ALL_ONES, ID_ALL_ONES);
        send_item(OP_SPARE_MID, id_t'(1), id_t'(1));
        send_item(OP_SPARE_HI, '0, '0);
        send_item(OP_QUERY, '0, '0);
        send_item(OP_QUERY, id_t'(1), '0);
        send_item(OP_REBUILD, ID_ALL_ONES, ID_ALL_ONES);
        send_item(OP_QUERY, '0, '0);
        send_item(OP_AFTER, MAX_ID, MAX_ID - id_t'(1));  // already right there
        wait_drained();

        // Random phases, each behind a fresh count write
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 4) begin
                snd_idle_pct = 46;
                rcv_idle_pct = 26;
            end else if (ph == 7) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            write_count(counts[ph]);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                make_item(sb.count, op, it, an);
                send_item(op, it, an);
            end
            wait_drained();
        end

        repeat (END_SLACK) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_replies.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
